// ===== rtl/core/packed_id_nibble_decoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// packed_id_nibble_decoder_core_macros
// Assertion macros for the packed identifier decoder. Empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef PACKED_ID_NIBBLE_DECODER_CORE_MACROS_SVH
`define PACKED_ID_NIBBLE_DECODER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication on clk, disabled in reset
`define PIDND_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidnd same-cycle check failed");
// next-cycle implication on clk, disabled in reset
`define PIDND_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidnd next-cycle check failed");
`else
`define PIDND_ASSERT_IMP(label, ante, cons)
`define PIDND_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/pidnd_pkg.sv =====
// ----------------------------------------------------------------------------
// pidnd_pkg
// Shared types, constants and helpers of the packed identifier decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pidnd_pkg;

    localparam int EXTRA_CHARS_DEF    = 4;
    localparam int MAX_CHAR_BYTES_DEF = 6;
    localparam int NUM_CHAR_REGS      = 4;

    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 3;
    localparam int XCNT_W     = 3;

    localparam logic [7:0]       RAW_MARK    = 8'hFF;
    localparam logic [3:0]       NIB_SKIP    = 4'h0;
    localparam logic [3:0]       NIB_END     = 4'hF;
    localparam logic [3:0]       DIGIT_MAX   = 4'hA;
    localparam logic [3:0]       EXTRA_FIRST = 4'hB;
    localparam logic [7:0]       ASCII_BIAS  = 8'd47;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        REG_CHAR_A       = 3'd0,
        REG_CHAR_B       = 3'd1,
        REG_CHAR_C       = 3'd2,
        REG_CHAR_D       = 3'd3,
        REG_EXTRA_COUNT  = 3'd4,
        REG_OUTPUT_LIMIT = 3'd5
    } pidnd_reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_LIMIT = 2'd1,
        ST_UNDEF = 2'd2
    } pidnd_status_t;

    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_END,
        KIND_DIGIT,
        KIND_EXTRA
    } pidnd_kind_t;

    typedef struct packed {
        logic          load;
        logic          start;
        logic          emit_raw;
        logic          emit_digit;
        logic          emit_x;
        logic          x_begin;
        logic          close;
        pidnd_status_t close_st;
        logic          nib_next;
        logic          flush;
    } pidnd_cmd_t;

    typedef struct packed {
        logic        first;
        logic        last;
        logic        is_mark;
        logic        finished;
        logic        raw;
        logic        nib_lo;
        pidnd_kind_t kind;
        logic        digit_over;
        logic        x_undef;
        logic        x_over;
        logic        x_empty;
        logic        x_last;
        logic        pend_valid;
        logic        go;
    } pidnd_sts_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             string_done;
        logic [1:0]       status;
        logic [CNT_W-1:0] decoded_length;
        logic             run_last;
    } pidnd_result_t;

    // UTF-8 sequence length from the lead byte, 0 for a bad lead
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] lead);
        logic [LEN_W-1:0] len;
        if (lead[7] == 1'b0)                   len = 3'd1;
        else if ((lead & 8'hE0) == 8'hC0)      len = 3'd2;
        else if ((lead & 8'hF0) == 8'hE0)      len = 3'd3;
        else if ((lead & 8'hF8) == 8'hF0)      len = 3'd4;
        else if ((lead & 8'hFC) == 8'hF8)      len = 3'd5;
        else if ((lead & 8'hFE) == 8'hFC)      len = 3'd6;
        else                                   len = 3'd0;
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pidnd_if.sv =====
// ----------------------------------------------------------------------------
// pidnd_if
// Valid/ready stream interfaces for packed input bytes and decoded words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pidnd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_string;
    logic       last_of_string;

    modport source (output valid, in_byte, first_of_string, last_of_string, input ready);
    modport sink   (input valid, in_byte, first_of_string, last_of_string, output ready);
endinterface

interface pidnd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        string_done;
    logic [1:0]  status;
    logic [15:0] decoded_length;
    logic        run_last;

    modport source (output valid, out_byte, byte_valid, string_done, status,
                    decoded_length, run_last, input ready);
    modport sink   (input valid, out_byte, byte_valid, string_done, status,
                    decoded_length, run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pidnd_regs.sv =====
// ----------------------------------------------------------------------------
// pidnd_regs
// APB register file: extra character table, extra count and output limit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidnd_regs
    import pidnd_pkg::*;
#(
    parameter int EXTRA_CHARS    = EXTRA_CHARS_DEF,
    parameter int MAX_CHAR_BYTES = MAX_CHAR_BYTES_DEF,
    localparam int CHAR_W        = 8 * MAX_CHAR_BYTES
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [CHAR_W-1:0]     chars [EXTRA_CHARS],
    output logic      [XCNT_W-1:0]     extra_count,
    output logic      [CNT_W-1:0]      output_limit
);

    logic [CHAR_W-1:0] chars_reg [EXTRA_CHARS];
    logic [XCNT_W-1:0] extra_count_reg;
    logic [CNT_W-1:0]  output_limit_reg;
    logic [2:0]        reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EXTRA_CHARS; i++)
            begin
                chars_reg[i] <= '0;
            end
            extra_count_reg  <= '0;
            output_limit_reg <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            for (int i = 0; i < EXTRA_CHARS; i++)
            begin
                if (reg_idx == 3'(REG_CHAR_A) + 3'(i))
                begin
                    chars_reg[i] <= pwdata[CHAR_W-1:0];
                end
            end
            case (reg_idx)
                REG_EXTRA_COUNT:  extra_count_reg  <= pwdata[XCNT_W-1:0];
                REG_OUTPUT_LIMIT: output_limit_reg <= pwdata[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int i = 0; i < EXTRA_CHARS; i++)
        begin
            if (reg_idx == 3'(REG_CHAR_A) + 3'(i))
            begin
                prdata = CFG_DATA_W'(chars_reg[i]);
            end
        end
        case (reg_idx)
            REG_EXTRA_COUNT:  prdata = CFG_DATA_W'(extra_count_reg);
            REG_OUTPUT_LIMIT: prdata = CFG_DATA_W'(output_limit_reg);
            default:          ;
        endcase
    end

    assign chars        = chars_reg;
    assign extra_count  = extra_count_reg;
    assign output_limit = output_limit_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pidnd_dp.sv =====
// ----------------------------------------------------------------------------
// pidnd_dp
// Datapath: input latch, string state, nibble decode, pending word and
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidnd_dp
    import pidnd_pkg::*;
#(
    parameter int EXTRA_CHARS    = EXTRA_CHARS_DEF,
    parameter int MAX_CHAR_BYTES = MAX_CHAR_BYTES_DEF,
    localparam int CHAR_W        = 8 * MAX_CHAR_BYTES,
    localparam int K_W           = (MAX_CHAR_BYTES > 1) ? $clog2(MAX_CHAR_BYTES) : 1
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_first,
    input  wire logic              in_last,
    input  wire logic [CHAR_W-1:0] chars [EXTRA_CHARS],
    input  wire logic [XCNT_W-1:0] extra_count,
    input  wire logic [CNT_W-1:0]  output_limit,
    input  wire pidnd_cmd_t        cmd,
    output pidnd_sts_t             sts,
    output pidnd_result_t          res,
    output logic                   res_valid,
    input  wire logic              res_ready
);

    logic [7:0]       byte_reg;
    logic             first_reg;
    logic             last_reg;
    logic             raw_reg;
    logic             fin_reg;
    logic [CNT_W-1:0] count_reg;
    logic             nib_lo_reg;
    logic [1:0]       xidx_reg;
    logic [LEN_W-1:0] xlen_reg;
    logic [K_W-1:0]   k_reg;
    logic             pend_valid_reg;
    pidnd_result_t    pend_reg;
    logic             out_valid_reg;
    pidnd_result_t    out_reg;
    pidnd_result_t    out_next;

    logic [3:0]        nib;
    pidnd_kind_t       kind;
    logic [1:0]        code_idx;
    logic [XCNT_W-1:0] avail;
    logic [CHAR_W-1:0] code_char;
    logic [LEN_W-1:0]  code_len_raw;
    logic [LEN_W-1:0]  code_len;
    logic [CHAR_W-1:0] x_char;
    logic [7:0]        x_byte;
    logic [CNT_W:0]    x_total;
    logic [CNT_W-1:0]  count_inc;
    logic              is_emit;
    logic              produce;
    logic              slot_free;
    pidnd_result_t     new_item;

    assign nib = nib_lo_reg ? byte_reg[3:0] : byte_reg[7:4];

    always_comb
    begin
        if (nib == NIB_SKIP)
        begin
            kind = KIND_SKIP;
        end
        else if (nib == NIB_END)
        begin
            kind = KIND_END;
        end
        else if (nib <= DIGIT_MAX)
        begin
            kind = KIND_DIGIT;
        end
        else
        begin
            kind = KIND_EXTRA;
        end
    end

    assign code_idx = 2'(nib - EXTRA_FIRST);
    assign avail    = (extra_count > XCNT_W'(EXTRA_CHARS)) ? XCNT_W'(EXTRA_CHARS) : extra_count;

    always_comb
    begin
        code_char = '0;
        x_char    = '0;
        for (int i = 0; i < EXTRA_CHARS; i++)
        begin
            if (code_idx == 2'(i))
            begin
                code_char = chars[i];
            end
            if (xidx_reg == 2'(i))
            begin
                x_char = chars[i];
            end
        end
    end

    assign code_len_raw = lead_length(code_char[7:0]);
    assign code_len     = (code_len_raw > LEN_W'(MAX_CHAR_BYTES)) ?
                          LEN_W'(MAX_CHAR_BYTES) : code_len_raw;
    assign x_total      = {1'b0, count_reg} + (CNT_W+1)'(code_len);
    assign x_byte       = x_char[8*k_reg +: 8];
    assign count_inc    = count_reg + CNT_W'(1);

    assign is_emit   = cmd.emit_raw || cmd.emit_digit || cmd.emit_x;
    assign produce   = is_emit || cmd.close;
    assign slot_free = !out_valid_reg || res_ready;

    always_comb
    begin
        new_item.out_byte       = 8'h00;
        if (cmd.emit_raw)
        begin
            new_item.out_byte = byte_reg;
        end
        else if (cmd.emit_digit)
        begin
            new_item.out_byte = 8'(nib) + ASCII_BIAS;
        end
        else if (cmd.emit_x)
        begin
            new_item.out_byte = x_byte;
        end
        new_item.byte_valid     = is_emit;
        new_item.string_done    = cmd.close;
        new_item.status         = cmd.close ? cmd.close_st : ST_OK;
        new_item.decoded_length = is_emit ? count_inc : count_reg;
        new_item.run_last       = 1'b0;
    end

    always_comb
    begin
        out_next          = pend_reg;
        out_next.run_last = cmd.flush;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            count_reg      <= '0;
            nib_lo_reg     <= 1'b0;
            xidx_reg       <= '0;
            xlen_reg       <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                nib_lo_reg <= 1'b0;
                if (first_reg)
                begin
                    raw_reg   <= (byte_reg == RAW_MARK);
                    fin_reg   <= 1'b0;
                    count_reg <= '0;
                end
            end
            if (is_emit)
            begin
                count_reg <= count_inc;
            end
            if (cmd.close)
            begin
                fin_reg <= 1'b1;
            end
            if (cmd.nib_next)
            begin
                nib_lo_reg <= 1'b1;
            end
            if (cmd.x_begin)
            begin
                xidx_reg <= code_idx;
                xlen_reg <= code_len;
                k_reg    <= '0;
            end
            else if (cmd.emit_x)
            begin
                k_reg <= k_reg + K_W'(1);
            end

            if (produce)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if ((produce || cmd.flush) && pend_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg  <= in_byte;
            first_reg <= in_first;
            last_reg  <= in_last;
        end
        if (produce)
        begin
            pend_reg <= new_item;
        end
        if ((produce || cmd.flush) && pend_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        sts.first      = first_reg;
        sts.last       = last_reg;
        sts.is_mark    = (byte_reg == RAW_MARK);
        sts.finished   = fin_reg;
        sts.raw        = raw_reg;
        sts.nib_lo     = nib_lo_reg;
        sts.kind       = kind;
        sts.digit_over = (count_reg >= output_limit);
        sts.x_undef    = ({1'b0, code_idx} >= avail);
        sts.x_over     = (x_total > {1'b0, output_limit});
        sts.x_empty    = (code_len == '0);
        sts.x_last     = ((LEN_W'(k_reg) + LEN_W'(1)) == xlen_reg);
        sts.pend_valid = pend_valid_reg;
        sts.go         = !pend_valid_reg || slot_free;
    end

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pidnd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidnd_ctrl
// Sequencer: walks one packed byte through start, a raw byte step or nibble
// steps and extra character bytes, closing check and flush of the last word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pidnd_ctrl
    import pidnd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire pidnd_sts_t sts,
    output pidnd_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RAW,
        S_CODE,
        S_XEMIT,
        S_LAST,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.start = 1'b1;
                if (sts.first && sts.is_mark)
                begin
                    state_next = S_LAST;
                end
                else if (!sts.first && sts.finished)
                begin
                    state_next = S_IDLE;
                end
                else if (!sts.first && sts.raw)
                begin
                    state_next = S_RAW;
                end
                else
                begin
                    state_next = S_CODE;
                end
            end
            S_RAW:
            begin
                if (sts.go)
                begin
                    if (sts.digit_over)
                    begin
                        cmd.close    = 1'b1;
                        cmd.close_st = ST_LIMIT;
                    end
                    else
                    begin
                        cmd.emit_raw = 1'b1;
                    end
                    state_next = S_LAST;
                end
            end
            S_CODE:
            begin
                if (sts.go)
                begin
                    case (sts.kind)
                        KIND_END:
                        begin
                            cmd.close    = 1'b1;
                            cmd.close_st = ST_OK;
                            state_next   = S_FLUSH;
                        end
                        KIND_DIGIT:
                        begin
                            if (sts.digit_over)
                            begin
                                cmd.close    = 1'b1;
                                cmd.close_st = ST_LIMIT;
                                state_next   = S_FLUSH;
                            end
                            else
                            begin
                                cmd.emit_digit = 1'b1;
                                cmd.nib_next   = !sts.nib_lo;
                                state_next     = sts.nib_lo ? S_LAST : S_CODE;
                            end
                        end
                        KIND_EXTRA:
                        begin
                            if (sts.x_undef)
                            begin
                                cmd.close    = 1'b1;
                                cmd.close_st = ST_UNDEF;
                                state_next   = S_FLUSH;
                            end
                            else if (sts.x_over)
                            begin
                                cmd.close    = 1'b1;
                                cmd.close_st = ST_LIMIT;
                                state_next   = S_FLUSH;
                            end
                            else if (sts.x_empty)
                            begin
                                cmd.nib_next = !sts.nib_lo;
                                state_next   = sts.nib_lo ? S_LAST : S_CODE;
                            end
                            else
                            begin
                                cmd.x_begin = 1'b1;
                                state_next  = S_XEMIT;
                            end
                        end
                        default:
                        begin
                            cmd.nib_next = !sts.nib_lo;
                            state_next   = sts.nib_lo ? S_LAST : S_CODE;
                        end
                    endcase
                end
            end
            S_XEMIT:
            begin
                if (sts.go)
                begin
                    cmd.emit_x = 1'b1;
                    if (sts.x_last)
                    begin
                        cmd.nib_next = !sts.nib_lo;
                        state_next   = sts.nib_lo ? S_LAST : S_CODE;
                    end
                end
            end
            S_LAST:
            begin
                if (sts.go)
                begin
                    if (sts.last && !sts.finished)
                    begin
                        cmd.close    = 1'b1;
                        cmd.close_st = ST_OK;
                    end
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (sts.go)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

`default_nettype wire

// ===== rtl/core/packed_id_nibble_decoder_core.sv =====
// ----------------------------------------------------------------------------
// packed_id_nibble_decoder_core
// Packed identifier string decoder: raw pass-through after a 0xFF lead,
// otherwise two codes per byte to ASCII digits or configured UTF-8 chars.
// ----------------------------------------------------------------------------
//  channel     dir  handshake        word
//  enc_stream  in   valid/ready      in_byte, first_of_string, last_of_string
//  dec_stream  out  valid/ready      out_byte, byte_valid, string_done,
//                                    status, decoded_length, run_last
//  apb         in   psel/penable     64-bit registers at 8*index, pready = 1
//
//  One byte at a time through the sequencer: a new byte is accepted only once
//  the previous one is back in idle; each emitted extra-char byte is a step.
//  After start, a step waits while a word is held in the datapath and the
//  output register is full and not read; the held word lets run_last be set.
//  rst_n clears string state, the sequencer and the registers (limit 65535).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "packed_id_nibble_decoder_core_macros.svh"

module packed_id_nibble_decoder_core
    import pidnd_pkg::*;
#(
    parameter int EXTRA_CHARS    = EXTRA_CHARS_DEF,
    parameter int MAX_CHAR_BYTES = MAX_CHAR_BYTES_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    pidnd_in_if.sink                   enc_stream,
    pidnd_out_if.source                dec_stream,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int CHAR_W = 8 * MAX_CHAR_BYTES;

    logic [CHAR_W-1:0] chars [EXTRA_CHARS];
    logic [XCNT_W-1:0] extra_count;
    logic [CNT_W-1:0]  output_limit;
    pidnd_cmd_t        cmd;
    pidnd_sts_t        sts;
    pidnd_result_t     res;
    logic              res_valid;

    pidnd_regs #(
        .EXTRA_CHARS    (EXTRA_CHARS),
        .MAX_CHAR_BYTES (MAX_CHAR_BYTES)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .chars        (chars),
        .extra_count  (extra_count),
        .output_limit (output_limit)
    );

    pidnd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (enc_stream.valid),
        .in_ready (enc_stream.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pidnd_dp #(
        .EXTRA_CHARS    (EXTRA_CHARS),
        .MAX_CHAR_BYTES (MAX_CHAR_BYTES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (enc_stream.in_byte),
        .in_first     (enc_stream.first_of_string),
        .in_last      (enc_stream.last_of_string),
        .chars        (chars),
        .extra_count  (extra_count),
        .output_limit (output_limit),
        .cmd          (cmd),
        .sts          (sts),
        .res          (res),
        .res_valid    (res_valid),
        .res_ready    (dec_stream.ready)
    );

    assign dec_stream.valid          = res_valid;
    assign dec_stream.out_byte       = res.out_byte;
    assign dec_stream.byte_valid     = res.byte_valid;
    assign dec_stream.string_done    = res.string_done;
    assign dec_stream.status         = res.status;
    assign dec_stream.decoded_length = res.decoded_length;
    assign dec_stream.run_last       = res.run_last;

    `PIDND_ASSERT_IMP(a_accept_no_pending, enc_stream.valid && enc_stream.ready, !sts.pend_valid)
    `PIDND_ASSERT_NXT(a_busy_after_accept, enc_stream.valid && enc_stream.ready, !enc_stream.ready)
    `PIDND_ASSERT_IMP(a_close_word_empty, dec_stream.valid && dec_stream.string_done, !dec_stream.byte_valid && (dec_stream.out_byte == 8'h00))
    `PIDND_ASSERT_IMP(a_status_on_close, dec_stream.valid && (dec_stream.status != ST_OK), dec_stream.string_done)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packed_id_nibble_decoder_core. Packed and raw
// strings go in through a randomly stalled stream. Every accepted byte runs
// through a local decoder model that queues the words it should produce.
// Each word from the block is compared field by field against that queue.
// The decoder registers are reprogrammed over APB between phases.
// ----------------------------------------------------------------------------

module testbench;

    import pidnd_pkg::*;

    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_WORDS  = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } enc_word_t;

    logic clk;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte  = 8'h00;
    logic       drv_first = 1'b0;
    logic       drv_last  = 1'b0;
    logic       drv_ready = 1'b0;

    pidnd_in_if  enc_if ();
    pidnd_out_if dec_if ();

    assign enc_if.valid           = drv_valid;
    assign enc_if.in_byte         = drv_byte;
    assign enc_if.first_of_string = drv_first;
    assign enc_if.last_of_string  = drv_last;
    assign dec_if.ready           = drv_ready;

    packed_id_nibble_decoder_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .enc_stream (enc_if),
        .dec_stream (dec_if),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // register shadow
    logic [47:0] xchar_val [NUM_CHAR_REGS];
    logic [2:0]  xchar_count = 3'd0;
    logic [15:0] out_limit   = 16'hFFFF;

    // string state of the decoder model
    logic           raw_mode    = 1'b0;
    logic           str_ended   = 1'b0;
    logic [15:0]    byte_cnt    = 16'd0;
    pidnd_status_t  end_status  = ST_OK;

    pidnd_result_t step_words [$];
    pidnd_result_t due_words [$];
    enc_word_t     enc_words [$];
    enc_word_t     next_word;

    int n_queued      = 0;
    int n_accepted    = 0;
    int n_fail        = 0;
    int send_idle_pct = 24;
    int recv_idle_pct = 45;
    int quiet_cycles  = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------- decoder model ----------------

    function automatic void push_word(logic [7:0] b, logic is_data, logic done);
        pidnd_result_t w;
        w.out_byte       = b;
        w.byte_valid     = is_data;
        w.string_done    = done;
        w.status         = done ? end_status : ST_OK;
        w.decoded_length = byte_cnt;
        w.run_last       = 1'b0;
        step_words.insert(step_words.size(), w);
    endfunction

    function automatic void emit(logic [7:0] b);
        byte_cnt = byte_cnt + 16'd1;
        push_word(b, 1'b1, 1'b0);
    endfunction

    function automatic void close_str(pidnd_status_t st);
        str_ended  = 1'b1;
        end_status = st;
        push_word(8'h00, 1'b0, 1'b1);
    endfunction

    function automatic int utf8_len(logic [7:0] lead);
        int n;
        casez (lead)
            8'b0???????: n = 1;
            8'b110?????: n = 2;
            8'b1110????: n = 3;
            8'b11110???: n = 4;
            8'b111110??: n = 5;
            8'b1111110?: n = 6;
            default:     n = 0;
        endcase
        return (n > MAX_CHAR_BYTES_DEF) ? MAX_CHAR_BYTES_DEF : n;
    endfunction

    function automatic void decode_nibble(logic [3:0] code);
        int idx;
        int avail;
        int n;
        logic [47:0] chr;
        if (code == NIB_SKIP)
            return;
        if (code == NIB_END)
        begin
            close_str(ST_OK);
        end
        else if (code <= DIGIT_MAX)
        begin
            if (byte_cnt >= out_limit)
                close_str(ST_LIMIT);
            else
                emit(ASCII_BIAS + {4'h0, code});
        end
        else
        begin
            idx   = int'(code - EXTRA_FIRST);
            avail = (xchar_count > EXTRA_CHARS_DEF) ? EXTRA_CHARS_DEF : int'(xchar_count);
            if (idx >= avail)
            begin
                close_str(ST_UNDEF);
            end
            else
            begin
                chr = xchar_val[idx];
                n   = utf8_len(chr[7:0]);
                if (int'(byte_cnt) + n > int'(out_limit))
                    close_str(ST_LIMIT);
                else
                    for (int i = 0; i < n; i++)
                        emit(chr[8*i +: 8]);
            end
        end
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic first, logic last);
        logic mark_only;
        mark_only = 1'b0;
        step_words.delete();
        if (first)
        begin
            raw_mode   = 1'b0;
            str_ended  = 1'b0;
            byte_cnt   = 16'd0;
            end_status = ST_OK;
            if (b == RAW_MARK)
            begin
                raw_mode  = 1'b1;
                mark_only = 1'b1;
                if (last)
                    close_str(ST_OK);
            end
        end
        else if (str_ended)
        begin
            return;
        end
        if (!mark_only)
        begin
            if (raw_mode)
            begin
                if (byte_cnt >= out_limit)
                    close_str(ST_LIMIT);
                else
                    emit(b);
            end
            else
            begin
                decode_nibble(b[7:4]);
                if (!str_ended)
                    decode_nibble(b[3:0]);
            end
            if (last && !str_ended)
                close_str(ST_OK);
        end
        if (step_words.size() != 0)
            step_words[step_words.size() - 1].run_last = 1'b1;
        while (step_words.size() != 0)
            due_words.insert(due_words.size(), step_words.pop_front());
    endfunction

    // ---------------- input driver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else
        begin
            if (enc_if.valid && enc_if.ready)
            begin
                decode_byte(enc_if.in_byte, enc_if.first_of_string, enc_if.last_of_string);
                n_accepted++;
            end
            if (!drv_valid || enc_if.ready)
            begin
                if (enc_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = enc_words.pop_front();
                    drv_valid <= 1'b1;
                    drv_byte  <= next_word.data;
                    drv_first <= next_word.first;
                    drv_last  <= next_word.last;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- output monitor ----------------

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk)
    begin
        pidnd_result_t exp_w;
        if (!rst_n)
        begin
            drv_ready <= 1'b0;
        end
        else
        begin
            drv_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (dec_if.valid && dec_if.ready)
            begin
                if (due_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none got byte 0x%0h done %0d",
                             $time, dec_if.out_byte, dec_if.string_done);
                    n_fail++;
                end
                else
                begin
                    exp_w = due_words.pop_front();
                    check_field("out_byte", exp_w.out_byte, dec_if.out_byte);
                    check_field("byte_valid", exp_w.byte_valid, dec_if.byte_valid);
                    check_field("string_done", exp_w.string_done, dec_if.string_done);
                    check_field("status", exp_w.status, dec_if.status);
                    check_field("decoded_length", exp_w.decoded_length,
                                dec_if.decoded_length);
                    check_field("run_last", exp_w.run_last, dec_if.run_last);
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if ((enc_if.valid && enc_if.ready) || (dec_if.valid && dec_if.ready) || psel
            || !rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: watchdog, no handshake for %0d cycles, %0d words due",
                     $time, STALL_LIMIT, due_words.size());
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_word(logic [7:0] b, logic first, logic last);
        enc_word_t w;
        w.data  = b;
        w.first = first;
        w.last  = last;
        enc_words.insert(enc_words.size(), w);
        n_queued++;
    endtask

    task automatic write_reg(pidnd_reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_EXTRA_COUNT:  xchar_count = val[2:0];
            REG_OUTPUT_LIMIT: out_limit   = val[15:0];
            default:          xchar_val[int'(idx)] = val[47:0];
        endcase
    endtask

    task automatic set_config(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                              logic [47:0] d, logic [2:0] cnt, logic [15:0] lim);
        write_reg(REG_CHAR_A, {16'h0, a});
        write_reg(REG_CHAR_B, {16'h0, b});
        write_reg(REG_CHAR_C, {16'h0, c});
        write_reg(REG_CHAR_D, {16'h0, d});
        write_reg(REG_EXTRA_COUNT, {61'h0, cnt});
        write_reg(REG_OUTPUT_LIMIT, {48'h0, lim});
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (n_accepted != n_queued || due_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [47:0] rand_char();
        logic [47:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(6))
            0: v[7]   = 1'b0;
            1: v[7:5] = 3'b110;
            2: v[7:4] = 4'b1110;
            3: v[7:3] = 5'b11110;
            4: v[7:2] = 6'b111110;
            5: v[7:1] = 7'b1111110;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_limit();
        case ($urandom_range(4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 12));
            default: return 16'($urandom_range(13, 60));
        endcase
    endfunction

    function automatic logic [3:0] rand_code();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 4'($urandom_range(1, 10));
        else if (r < 80)
            return 4'($urandom_range(11, 14));
        else if (r < 95)
            return NIB_SKIP;
        else
            return NIB_END;
    endfunction

    task automatic add_packed_string(logic closed);
        int len;
        logic [7:0] b;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            b = {rand_code(), rand_code()};
            if (i == 0 && b == RAW_MARK)
                b = 8'h12;
            queue_word(b, i == 0, closed && i == len - 1);
        end
    endtask

    task automatic add_raw_string();
        int len;
        len = $urandom_range(0, 10);
        queue_word(RAW_MARK, 1'b1, len == 0);
        for (int i = 0; i < len; i++)
            queue_word(8'($urandom), 1'b0, i == len - 1);
    endtask

    task automatic add_random_phase();
        int start;
        int r;
        start = n_queued;
        while (n_queued - start < PHASE_WORDS)
        begin
            r = $urandom_range(99);
            if (r < 65)
                add_packed_string(1'b1);
            else if (r < 80)
                add_raw_string();
            else if (r < 90)
                add_packed_string(1'b0);
            else
                queue_word(8'($urandom), 1'($urandom), 1'($urandom));
        end
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CHAR_REGS; i++)
            xchar_val[i] = 48'h0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // string already in progress after reset, then raw strings
        queue_word(8'h12, 1'b0, 1'b0);
        queue_word(8'h3B, 1'b0, 1'b0);
        queue_word(8'h45, 1'b0, 1'b1);
        queue_word(RAW_MARK, 1'b1, 1'b1);
        queue_word(RAW_MARK, 1'b1, 1'b0);
        queue_word(8'h00, 1'b0, 1'b0);
        queue_word(8'hFF, 1'b0, 1'b0);
        queue_word(8'hAB, 1'b0, 1'b1);
        wait_drained();

        // 1, 2 and 6 byte chars, one bad lead, limit of 8
        set_config(48'h00000000_0041, 48'h00000000_A9C3, 48'h8F8E8D8C8BFC,
                   48'h1234567890FE, 3'd4, 16'd8);
        queue_word(8'h1A, 1'b1, 1'b0);
        queue_word(8'hBC, 1'b0, 1'b0);
        queue_word(8'h0D, 1'b0, 1'b0);
        queue_word(8'hE0, 1'b1, 1'b1);
        queue_word(8'hF5, 1'b1, 1'b0);
        queue_word(8'h55, 1'b0, 1'b1);
        queue_word(8'h11, 1'b1, 1'b0);
        queue_word(8'h22, 1'b1, 1'b1);
        queue_word(8'h0D, 1'b1, 1'b0);
        queue_word(8'h12, 1'b0, 1'b0);
        queue_word(8'h30, 1'b0, 1'b1);
        wait_drained();

        // zero limit, two chars usable
        write_reg(REG_EXTRA_COUNT, 64'd2);
        write_reg(REG_OUTPUT_LIMIT, 64'd0);
        queue_word(8'h12, 1'b1, 1'b1);
        queue_word(8'hC1, 1'b1, 1'b1);
        queue_word(8'hD1, 1'b1, 1'b1);
        queue_word(RAW_MARK, 1'b1, 1'b0);
        queue_word(8'h80, 1'b0, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_config(48'h0, 48'hFFFF_FFFF_FFFF, rand_char(), rand_char(),
                           3'd7, 16'hFFFF);
            else
                set_config(rand_char(), rand_char(), rand_char(), rand_char(),
                           ($urandom_range(3) == 0) ? 3'($urandom_range(7))
                                                    : 3'($urandom_range(4)),
                           rand_limit());
            if (phase < 2)
            begin
                send_idle_pct = 24;
                recv_idle_pct = 45;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 24;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            add_random_phase();
            wait_drained();
        end

        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
